@@ design/cfpr_pkg.sv @@
// Shared constants for the framed packet receiver: payload store size,
// field widths, configuration register indexes, frame kinds and CRC terms.
// No dependencies.
`default_nettype none

package cfpr_pkg;

	localparam int PAYLOAD_DEPTH = 32;
	localparam int PAY_AW        = $clog2(PAYLOAD_DEPTH);
	localparam int LEN_W         = $clog2(PAYLOAD_DEPTH + 1);

	localparam int KIND_W     = 2;
	localparam int OUT_LEN_W  = 6;
	localparam int OUT_IDX_W  = 5;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_SYNC    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIG  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LED     = 3'd4;

	localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CONFIG = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LED    = 2'd2;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

endpackage

`default_nettype wire

@@ design/crc_framed_packet_receiver_core.sv @@
// Framed packet receiver: sync hunt, header parse, bit-serial CRC-16 check
// and payload replay. Depends on cfpr_pkg and cfpr_ram.
// Bytes covered by the CRC (version, type, length, payload) are taken, then
// shifted into the CRC one bit at a time; other bytes need no shift.
// After the last CRC byte is taken, each result takes a RAM read (ST_RD) and
// a load into the output register (ST_LOAD), which waits for it to be free;
// an empty frame skips the read. The input is not ready during the replay.
// Reset clears the parser, the output valid and the configuration registers;
// the payload RAM is not cleared.
`default_nettype none

module crc_framed_packet_receiver_core
	import cfpr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [7:0]           cfg_wdata,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// [5:0] payload_length, [10:6] byte_index, [18:11] payload_byte, [23:19] zero
	output logic [23:0]               m_axis_tdata,
	output logic [2:0]                m_axis_tuser,   // [1:0] frame_kind, [2] has_payload
	output logic                      m_axis_tlast
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SHIFT = 2'd1;
	localparam logic [1:0] ST_RD    = 2'd2;
	localparam logic [1:0] ST_LOAD  = 2'd3;

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_VER  = 3'd1;
	localparam logic [2:0] PH_TYPE = 3'd2;
	localparam logic [2:0] PH_LEN  = 3'd3;
	localparam logic [2:0] PH_PAY  = 3'd4;
	localparam logic [2:0] PH_CRCL = 3'd5;
	localparam logic [2:0] PH_CRCH = 3'd6;

	logic [1:0]           st_q;
	logic [2:0]           phase_q;
	logic [2:0]           bit_cnt_q;
	logic [7:0]           sync_q, ver_q, ack_q, conf_q, led_q;
	logic [15:0]          crc_q;
	logic [7:0]           sh_q;
	logic [7:0]           type_q;
	logic [7:0]           crcl_q;
	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     fill_q;
	logic [PAY_AW-1:0]    k_q;
	logic [KIND_W-1:0]    kind_q;
	logic                 m_valid_q;
	logic [KIND_W-1:0]    out_kind_q;
	logic [OUT_LEN_W-1:0] out_len_q;
	logic                 out_has_q;
	logic [OUT_IDX_W-1:0] out_idx_q;
	logic [7:0]           out_byte_q;
	logic                 out_last_q;

	logic                 in_fire;
	logic                 out_fire;
	logic                 out_free;
	logic [7:0]           rx_b;
	logic                 fb;
	logic [15:0]          crc_next;
	logic [LEN_W-1:0]     fill_inc;
	logic                 crc_ok;
	logic                 kind_hit;
	logic [KIND_W-1:0]    kind_sel;
	logic                 run_last;
	logic                 ram_wr_en;
	logic                 ram_rd_en;
	logic [7:0]           ram_rdata;

	assign rx_b     = s_axis_tdata;
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_valid_q && m_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (st_q == ST_IDLE);

	assign fb       = crc_q[15] ^ sh_q[7];
	assign crc_next = {crc_q[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
	assign fill_inc = fill_q + LEN_W'(1);
	assign crc_ok   = (rx_b == crc_q[15:8]) && (crcl_q == crc_q[7:0]);
	assign run_last = ((LEN_W'(k_q) + LEN_W'(1)) == len_q);

	always_comb begin
		kind_hit = 1'b1;
		kind_sel = KIND_ACK;
		if (type_q == ack_q) begin
			kind_sel = KIND_ACK;
		end else if (type_q == conf_q) begin
			kind_sel = KIND_CONFIG;
		end else if (type_q == led_q) begin
			kind_sel = KIND_LED;
		end else begin
			kind_hit = 1'b0;
		end
	end

	assign ram_wr_en = in_fire && (st_q == ST_IDLE) && (phase_q == PH_PAY);
	assign ram_rd_en = (st_q == ST_RD);

	cfpr_ram #(
		.WIDTH(8),
		.DEPTH(PAYLOAD_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (fill_q[PAY_AW-1:0]),
		.wr_data (rx_b),
		.rd_en   (ram_rd_en),
		.rd_addr (k_q),
		.rd_data (ram_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= '0;
			ver_q  <= '0;
			ack_q  <= '0;
			conf_q <= '0;
			led_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				CFG_SYNC: begin
					sync_q <= cfg_wdata;
				end
				CFG_VERSION: begin
					ver_q <= cfg_wdata;
				end
				CFG_ACK: begin
					ack_q <= cfg_wdata;
				end
				CFG_CONFIG: begin
					conf_q <= cfg_wdata;
				end
				CFG_LED: begin
					led_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			phase_q   <= PH_HUNT;
			bit_cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if ((st_q == ST_LOAD) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (out_fire) begin
				m_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (phase_q)
							PH_VER: begin
								st_q      <= ST_SHIFT;
								bit_cnt_q <= '0;
								phase_q   <= (rx_b == ver_q) ? PH_TYPE : PH_HUNT;
							end
							PH_TYPE: begin
								st_q      <= ST_SHIFT;
								bit_cnt_q <= '0;
								phase_q   <= PH_LEN;
							end
							PH_LEN: begin
								st_q      <= ST_SHIFT;
								bit_cnt_q <= '0;
								if (rx_b > 8'(PAYLOAD_DEPTH)) begin
									phase_q <= PH_HUNT;
								end else if (rx_b == 8'd0) begin
									phase_q <= PH_CRCL;
								end else begin
									phase_q <= PH_PAY;
								end
							end
							PH_PAY: begin
								st_q      <= ST_SHIFT;
								bit_cnt_q <= '0;
								if (fill_inc >= len_q) begin
									phase_q <= PH_CRCL;
								end
							end
							PH_CRCL: begin
								phase_q <= PH_CRCH;
							end
							PH_CRCH: begin
								phase_q <= PH_HUNT;
								if (crc_ok && kind_hit) begin
									st_q <= (len_q == '0) ? ST_LOAD : ST_RD;
								end
							end
							default: begin
								phase_q <= (rx_b == sync_q) ? PH_VER : PH_HUNT;
							end
						endcase
					end
				end
				ST_SHIFT: begin
					bit_cnt_q <= bit_cnt_q + 3'd1;
					if (bit_cnt_q == 3'd7) begin
						st_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					st_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						if (len_q == '0 || run_last) begin
							st_q <= ST_IDLE;
						end else begin
							st_q <= ST_RD;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (in_fire) begin
					sh_q <= rx_b;
					case (phase_q)
						PH_VER: begin
							crc_q <= CRC_INIT;
						end
						PH_TYPE: begin
							type_q <= rx_b;
						end
						PH_LEN: begin
							len_q  <= rx_b[LEN_W-1:0];
							fill_q <= '0;
						end
						PH_PAY: begin
							fill_q <= fill_inc;
						end
						PH_CRCL: begin
							crcl_q <= rx_b;
						end
						PH_CRCH: begin
							kind_q <= kind_sel;
							k_q    <= '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SHIFT: begin
				crc_q <= crc_next;
				sh_q  <= {sh_q[6:0], 1'b0};
			end
			ST_LOAD: begin
				if (out_free) begin
					out_kind_q <= kind_q;
					if (len_q == '0) begin
						out_len_q  <= '0;
						out_has_q  <= 1'b0;
						out_idx_q  <= '0;
						out_byte_q <= '0;
						out_last_q <= 1'b1;
					end else begin
						out_len_q  <= OUT_LEN_W'(len_q);
						out_has_q  <= 1'b1;
						out_idx_q  <= OUT_IDX_W'(k_q);
						out_byte_q <= ram_rdata;
						out_last_q <= run_last;
						k_q        <= k_q + PAY_AW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'd0, out_byte_q, out_idx_q, out_len_q};
	assign m_axis_tuser  = {out_has_q, out_kind_q};
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ design/cfpr_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module cfpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire
